/* hw/rtl/ootb_pkg.sv */
// Shared types and constants for the out-of-the-blue chunk filter.
package ootb_pkg;

    localparam int DATA_W    = 8;
    localparam int VERDICT_W = 2;
    localparam int OFFSET_W  = 16;
    localparam int PADLEN_W  = 17;

    localparam logic [VERDICT_W-1:0] VERDICT_KEEP      = 2'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_DISCARD   = 2'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_MALFORMED = 2'd2;

    localparam logic [DATA_W-1:0] TYPE_ABORT             = 8'd6;
    localparam logic [DATA_W-1:0] TYPE_ERROR             = 8'd9;
    localparam logic [DATA_W-1:0] TYPE_COOKIE_ACK        = 8'd11;
    localparam logic [DATA_W-1:0] TYPE_SHUTDOWN_COMPLETE = 8'd14;

    localparam logic [2*DATA_W-1:0] CAUSE_STALE_COOKIE = 16'd3;

    // Chunk offsets of the header and first cause fields.
    localparam logic [OFFSET_W-1:0] OFF_TYPE       = 16'd0;
    localparam logic [OFFSET_W-1:0] OFF_LEN_HIGH   = 16'd2;
    localparam logic [OFFSET_W-1:0] OFF_LEN_LOW    = 16'd3;
    localparam logic [OFFSET_W-1:0] OFF_CAUSE_HIGH = 16'd4;
    localparam logic [OFFSET_W-1:0] OFF_CAUSE_LOW  = 16'd5;

    localparam logic [2*DATA_W-1:0] MIN_CHUNK_LEN = 16'd4;

    typedef struct packed {
        logic                 load;
        logic [VERDICT_W-1:0] verdict;
        logic [DATA_W-1:0]    deciding_type;
    } t_result;

endpackage

/* hw/rtl/ootb_if.sv */
// Valid/ready channels for packet bytes and verdicts.
interface ootb_in_if;
    import ootb_pkg::*;
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data_byte;
    logic              last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ootb_out_if;
    import ootb_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [VERDICT_W-1:0] verdict;
    logic [DATA_W-1:0]    deciding_type;

    modport source (output valid, output verdict, output deciding_type, input ready);
    modport sink   (input valid, input verdict, input deciding_type, output ready);
endinterface

/* hw/rtl/ootb_in_stage.sv */
// Input register for packet byte requests.
module ootb_in_stage
    import ootb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [DATA_W-1:0] i_data_byte,
    input  logic              i_last_byte,
    input  logic              i_take,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_data_byte,
    output logic              o_last_byte
);

    logic              r_valid;
    logic [DATA_W-1:0] r_data_byte;
    logic              r_last_byte;

    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data_byte <= i_data_byte;
            r_last_byte <= i_last_byte;
        end
    end

    assign o_valid     = r_valid;
    assign o_data_byte = r_data_byte;
    assign o_last_byte = r_last_byte;

endmodule

/* hw/rtl/ootb_tracker.sv */
// Chunk walk state and per-byte decision logic.
module ootb_tracker
    import ootb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [DATA_W-1:0] i_data_byte,
    input  logic              i_last_byte,
    input  logic              i_out_free,
    output logic              o_take,
    output t_result           o_result
);

    logic [OFFSET_W-1:0]  r_offset,   n_offset;
    logic [PADLEN_W-1:0]  r_padlen,   n_padlen;
    logic [DATA_W-1:0]    r_type,     n_type;
    logic [DATA_W-1:0]    r_cause_hi, n_cause_hi;
    logic [DATA_W-1:0]    r_len_hi,   n_len_hi;
    logic [VERDICT_W-1:0] r_verdict,  n_verdict;
    logic [DATA_W-1:0]    r_dtype,    n_dtype;

    logic [VERDICT_W-1:0] ev_verdict;
    logic [DATA_W-1:0]    ev_type;
    logic [2*DATA_W-1:0]  len;
    logic [2*DATA_W-1:0]  cause;
    logic [PADLEN_W-1:0]  off_plus1;
    logic                 chunk_done;
    logic [VERDICT_W-1:0] fin_verdict;
    logic [DATA_W-1:0]    fin_type;

    // A last byte needs room in the result register; others always advance.
    assign o_take = i_valid && (!i_last_byte || i_out_free);

    assign len       = {r_len_hi, i_data_byte};
    assign cause     = {r_cause_hi, i_data_byte};
    assign off_plus1 = {1'b0, r_offset} + 17'd1;

    always_comb begin
        n_type     = r_type;
        n_cause_hi = r_cause_hi;
        n_len_hi   = r_len_hi;
        n_padlen   = r_padlen;
        ev_verdict = VERDICT_KEEP;
        ev_type    = '0;
        case (r_offset)
            OFF_TYPE: begin
                n_type     = i_data_byte;
                n_cause_hi = '0;
                if (i_data_byte == TYPE_ABORT || i_data_byte == TYPE_COOKIE_ACK ||
                    i_data_byte == TYPE_SHUTDOWN_COMPLETE) begin
                    ev_verdict = VERDICT_DISCARD;
                    ev_type    = i_data_byte;
                end
            end
            OFF_LEN_HIGH: begin
                n_len_hi = i_data_byte;
            end
            OFF_LEN_LOW: begin
                // Round up to a multiple of four.
                n_padlen = ({1'b0, len} + 17'd3) & 17'h1FFFC;
                if (len < MIN_CHUNK_LEN) begin
                    ev_verdict = VERDICT_MALFORMED;
                end
            end
            OFF_CAUSE_HIGH: begin
                n_cause_hi = i_data_byte;
            end
            OFF_CAUSE_LOW: begin
                if (r_type == TYPE_ERROR && cause == CAUSE_STALE_COOKIE) begin
                    ev_verdict = VERDICT_DISCARD;
                    ev_type    = r_type;
                end
            end
            default: ;
        endcase

        // First decision holds.
        if (r_verdict == VERDICT_KEEP) begin
            n_verdict = ev_verdict;
            n_dtype   = ev_type;
        end else begin
            n_verdict = r_verdict;
            n_dtype   = r_dtype;
        end

        fin_verdict = n_verdict;
        fin_type    = n_dtype;
        if (r_offset < OFF_LEN_LOW && n_verdict == VERDICT_KEEP) begin
            fin_verdict = VERDICT_MALFORMED;
            fin_type    = '0;
        end

        chunk_done = (r_offset >= OFF_LEN_LOW) && (off_plus1 >= n_padlen);
        n_offset   = chunk_done ? '0 : off_plus1[OFFSET_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (o_take && i_last_byte)) begin
            r_offset   <= '0;
            r_padlen   <= '0;
            r_type     <= '0;
            r_cause_hi <= '0;
            r_len_hi   <= '0;
            r_verdict  <= VERDICT_KEEP;
            r_dtype    <= '0;
        end else if (o_take) begin
            r_offset   <= n_offset;
            r_padlen   <= n_padlen;
            r_type     <= n_type;
            r_cause_hi <= n_cause_hi;
            r_len_hi   <= n_len_hi;
            r_verdict  <= n_verdict;
            r_dtype    <= n_dtype;
        end
    end

    assign o_result.load          = o_take && i_last_byte;
    assign o_result.verdict       = fin_verdict;
    assign o_result.deciding_type = fin_type;

endmodule

/* hw/rtl/ootb_out_stage.sv */
// Result register for verdict requests.
module ootb_out_stage
    import ootb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_result              i_result,
    output logic                 o_free,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [VERDICT_W-1:0] o_verdict,
    output logic [DATA_W-1:0]    o_deciding_type
);

    logic                 r_valid;
    logic [VERDICT_W-1:0] r_verdict;
    logic [DATA_W-1:0]    r_dtype;

    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_result.load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_result.load) begin
            r_verdict <= i_result.verdict;
            r_dtype   <= i_result.deciding_type;
        end
    end

    assign o_valid         = r_valid;
    assign o_verdict       = r_verdict;
    assign o_deciding_type = r_dtype;

endmodule

/* hw/rtl/ootb_packet_chunk_filter.sv */
// A byte request is held in the input register until the tracker processes it; a last
// byte's verdict is then registered in the result register and offered from there.
// Throughput: one byte per cycle; the input register and result register decouple
// both sides, so bytes other than the last keep flowing while a verdict waits to be
// taken; a last byte holds in the input register until the result register frees.
// Reset: synchronous, active low; clears both valid bits and the chunk walk state.
module ootb_packet_chunk_filter
    import ootb_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    ootb_in_if.sink    i_in,
    ootb_out_if.source o_out
);

    // Input register outputs.
    logic              in_valid;
    logic [DATA_W-1:0] in_data_byte;
    logic              in_last_byte;

    // Handshake between tracker and result register.
    logic    take;
    logic    out_free;
    t_result result;

    // Hold one byte request at a time; advance when the tracker takes it.
    ootb_in_stage u_in (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in.valid),
        .o_ready     (i_in.ready),
        .i_data_byte (i_in.data_byte),
        .i_last_byte (i_in.last_byte),
        .i_take      (take),
        .o_valid     (in_valid),
        .o_data_byte (in_data_byte),
        .o_last_byte (in_last_byte)
    );

    // Walk the chunk chain: offset compare, length rounding, first decision.
    // A last byte stalls only if the previous verdict is still waiting.
    ootb_tracker u_track (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (in_valid),
        .i_data_byte (in_data_byte),
        .i_last_byte (in_last_byte),
        .i_out_free  (out_free),
        .o_take      (take),
        .o_result    (result)
    );

    // Hold the verdict until the sink takes it.
    ootb_out_stage u_out (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_result        (result),
        .o_free          (out_free),
        .o_valid         (o_out.valid),
        .i_ready         (o_out.ready),
        .o_verdict       (o_out.verdict),
        .o_deciding_type (o_out.deciding_type)
    );

endmodule

/* hw/rtl/ootb_checker.sv */
// Port-level assertions for the chunk filter, bound to the top level.
module ootb_checker
    import ootb_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_out_valid,
    input logic                 i_out_ready,
    input logic [VERDICT_W-1:0] i_verdict,
    input logic [DATA_W-1:0]    i_deciding_type
);

    // Stalled verdict holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_verdict) && $stable(i_deciding_type))
        else $error("verdict changed while stalled");

    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_verdict == VERDICT_KEEP || i_verdict == VERDICT_DISCARD ||
                        i_verdict == VERDICT_MALFORMED)
        else $error("illegal verdict code");

    a_type_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_verdict != VERDICT_DISCARD |-> i_deciding_type == '0)
        else $error("deciding type set without discard");

    a_type_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_verdict == VERDICT_DISCARD |->
            i_deciding_type == TYPE_ABORT || i_deciding_type == TYPE_ERROR ||
            i_deciding_type == TYPE_COOKIE_ACK ||
            i_deciding_type == TYPE_SHUTDOWN_COMPLETE)
        else $error("discard by unexpected chunk type");

endmodule

bind ootb_packet_chunk_filter ootb_checker u_ootb_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_verdict       (o_out.verdict),
    .i_deciding_type (o_out.deciding_type)
);
